/* sv/dbss_pkg.sv */
// shared types, constants and segment decode for the seven-segment scanner
package dbss_pkg;

   localparam int unsigned ADDR_WIDTH  = 4;
   localparam int unsigned STORE_DEPTH = 16;
   localparam int unsigned CODE_WIDTH  = 4;
   localparam int unsigned POS_WIDTH   = 3;

   localparam logic [CODE_WIDTH-1:0] RESET_DIGIT = 4'd8;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_SWAP  = 2'd2,
      ACT_IDLE  = 2'd3
   } action_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_WIDTH-1:0] wr_addr;
      logic [CODE_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_WIDTH-1:0] rd_addr;
   } store_req_type;

   // active-high segment pattern, blank for codes ten and above
   function automatic logic [7:0] seg_pattern(input logic [CODE_WIDTH-1:0] code);
      logic [7:0] pat;
      case (code)
         4'd0:    pat = 8'b0011_1111;
         4'd1:    pat = 8'b0000_0011;
         4'd2:    pat = 8'b0110_1101;
         4'd3:    pat = 8'b0110_0111;
         4'd4:    pat = 8'b0101_0011;
         4'd5:    pat = 8'b0111_0110;
         4'd6:    pat = 8'b0111_1110;
         4'd7:    pat = 8'b0010_0011;
         4'd8:    pat = 8'b0111_1111;
         4'd9:    pat = 8'b0111_0111;
         default: pat = 8'b0000_0000;
      endcase
      return pat;
   endfunction

endpackage

/* sv/dbss_if.sv */
// request and response channel interfaces of the seven-segment scanner
interface dbss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [2:0] position;
   logic [3:0] digit_value;

   modport source (output valid, action, position, digit_value, input ready);
   modport sink   (input valid, action, position, digit_value, output ready);
endinterface

interface dbss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segments_n;
   logic [7:0] select_low_n;
   logic [1:0] select_high_n;

   modport source (output valid, segments_n, select_low_n, select_high_n, input ready);
   modport sink   (input valid, segments_n, select_low_n, select_high_n, output ready);
endinterface

/* sv/double_buffered_seven_segment_scanner.sv */
// top level of the double-buffered seven-segment scanner
// a scan tick's response passes through the store read register, then the output register
// one transaction of any kind is taken every cycle while the response side keeps up
// writes and swaps finish in the cycle they are accepted and give no response
// synchronous reset: all digits read as eight, upper bank in front, scan position zero
// the bank store itself is not swept; per-entry written flags stand in for its reset
module double_buffered_seven_segment_scanner #(
   parameter int unsigned DIGIT_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   dbss_req_if.sink     req_bus,
   dbss_rsp_if.source   rsp_bus
);

   localparam logic [dbss_pkg::POS_WIDTH-1:0] POS_LAST =
      dbss_pkg::POS_WIDTH'(DIGIT_COUNT - 1);

   dbss_pkg::action_type                    action;
   dbss_pkg::store_req_type                 store_req;
   logic [dbss_pkg::CODE_WIDTH-1:0]         rd_code;

   logic                                    front_bank_ff, front_bank_in;
   logic [dbss_pkg::POS_WIDTH-1:0]          scan_pos_ff, scan_pos_in;
   logic                                    s1_valid_ff, s1_valid_in;
   logic [dbss_pkg::POS_WIDTH-1:0]          s1_pos_ff;
   logic                                    out_valid_ff, out_valid_in;
   logic [7:0]                              seg_ff;
   logic [7:0]                              sel_lo_ff;
   logic [1:0]                              sel_hi_ff;

   logic accept, tick, out_free, s1_free, load_out;
   logic [7:0] sel_lo;
   logic [1:0] sel_hi;

   assign action   = dbss_pkg::action_type'(req_bus.action);
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign load_out = out_free && s1_valid_ff;

   assign req_bus.ready = s1_free;
   assign accept        = req_bus.valid && s1_free;
   assign tick          = accept && (action == dbss_pkg::ACT_TICK);

   // writes always land in the back bank and reads in the front, so they never collide
   always_comb begin
      store_req.wr_en   = accept && (action == dbss_pkg::ACT_WRITE);
      store_req.wr_addr = {!front_bank_ff, req_bus.position};
      store_req.wr_data = req_bus.digit_value;
      store_req.rd_en   = tick;
      store_req.rd_addr = {front_bank_ff, scan_pos_ff};
   end

   dbss_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_code (rd_code)
   );

   always_comb begin
      front_bank_in = front_bank_ff;
      scan_pos_in   = scan_pos_ff;
      if (accept && (action == dbss_pkg::ACT_SWAP)) begin
         front_bank_in = !front_bank_ff;
      end
      if (tick) begin
         scan_pos_in = (scan_pos_ff == POS_LAST) ? '0 : scan_pos_ff + 1'b1;
      end
      if (tick) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   // digit selects: positions six and seven sit on the two-bit group
   always_comb begin
      if (s1_pos_ff[2:1] == 2'b11) begin
         sel_lo = 8'hFF;
         sel_hi = ~(2'b01 << s1_pos_ff[0]);
      end else begin
         sel_lo = ~(8'b0000_0001 << s1_pos_ff);
         sel_hi = 2'b11;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_bank_ff <= 1'b1;
         scan_pos_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         front_bank_ff <= front_bank_in;
         scan_pos_ff   <= scan_pos_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         s1_pos_ff <= scan_pos_ff;
      end
      if (load_out) begin
         seg_ff    <= ~dbss_pkg::seg_pattern(rd_code);
         sel_lo_ff <= sel_lo;
         sel_hi_ff <= sel_hi;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.segments_n    = seg_ff;
   assign rsp_bus.select_low_n  = sel_lo_ff;
   assign rsp_bus.select_high_n = sel_hi_ff;

endmodule

/* sv/dbss_store.sv */
// two-bank digit store: synchronous memory with per-entry written flags
module dbss_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dbss_pkg::store_req_type              req,
   output logic [dbss_pkg::CODE_WIDTH-1:0]      rd_code
);

   logic [dbss_pkg::CODE_WIDTH-1:0] mem_ff [dbss_pkg::STORE_DEPTH];
   logic [dbss_pkg::STORE_DEPTH-1:0] written_ff;
   logic [dbss_pkg::CODE_WIDTH-1:0] rd_data_ff;
   logic                            rd_written_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            written_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_written_ff <= written_ff[req.rd_addr];
         end
      end
   end

   // entries never written since reset read as eight
   assign rd_code = rd_written_ff ? rd_data_ff : dbss_pkg::RESET_DIGIT;

endmodule
